@@ hw/rtl/bavg_pkg.sv @@
// ----------------------------------------------------------------------------
// bavg_pkg
// Shared constants and transaction types of the box average downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bavg_pkg;

    // Largest source image the column sum store is sized for.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Field widths.
    localparam int SIZE_W    = 13;
    localparam int COORD_W   = 12;
    localparam int PIXEL_W   = 8;
    localparam int SUM_W     = 32;
    localparam int COUNT_W   = 25;

    // Configuration port.
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_WIDTH  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_HEIGHT = 4'd3;

    // Queue between the front end and the accumulator.
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

    // One quotient bit per divider stage.
    localparam int DIV_STAGES = PIXEL_W;

    // Classified pixel, handed from the front end to the accumulator.
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               seed;     // first pixel of its bin in this band
        logic               emit;     // last pixel of its bin
        logic [COUNT_W-1:0] count;    // pixels in the bin
        logic [COORD_W-1:0] bin_col;
        logic [COORD_W-1:0] bin_row;
        logic               last;
    } t_job;

    // Finished bin, handed from the accumulator to the divider.
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic [COORD_W-1:0] bin_col;
        logic [COORD_W-1:0] bin_row;
        logic               last;
    } t_avg_req;

endpackage

`default_nettype wire

@@ hw/rtl/bavg_ram.sv @@
// ----------------------------------------------------------------------------
// bavg_ram
// Generic simple dual-port RAM with registered read (read before write).
// ----------------------------------------------------------------------------
`default_nettype none

module bavg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port; a read of the address being
    // written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bavg_front.sv @@
// ----------------------------------------------------------------------------
// bavg_front
// Configuration registers, bin step setup and raster position tracking.
// Classifies each accepted pixel and pushes it into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bavg_front import bavg_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [SIZE_W-1:0]      i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [PIXEL_W-1:0]     i_pixel_in,
    input  wire logic                   i_first_of_frame,
    output logic                        o_push,
    output t_job                        o_job,
    input  wire logic                   i_full
);

    typedef struct packed {
        logic [SIZE_W-1:0] num;
        logic [SIZE_W-1:0] rem;
    } t_dstep;

    // Size zero acts as one, sizes above the limit saturate.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // One step of a restoring division; the quotient shifts in from the right.
    function automatic t_dstep div_step(input t_dstep s, input logic [SIZE_W-1:0] den);
        logic [SIZE_W:0] t;
        t_dstep          res;
        t = {s.rem, s.num[SIZE_W-1]};
        if (t >= {1'b0, den}) begin
            res.rem = SIZE_W'(t - {1'b0, den});
            res.num = {s.num[SIZE_W-2:0], 1'b1};
        end else begin
            res.rem = t[SIZE_W-1:0];
            res.num = {s.num[SIZE_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // Written register values.
    logic [SIZE_W-1:0]  r_cfg_sw, r_cfg_sh, r_cfg_tw, r_cfg_th;
    // Effective sizes, latched when the setup starts.
    logic [SIZE_W-1:0]  r_sw, r_sh, r_tw, r_th;
    // Bin step: quotient and remainder of source size over target size.
    logic [SIZE_W-1:0]  r_qc, r_qr;
    logic [COORD_W-1:0] r_rc, r_rr;
    // Setup sequencer.
    logic               r_pend, r_busy;
    logic [3:0]         r_step;
    t_dstep             r_cdiv, r_rdiv;
    // Raster position.
    logic [COORD_W-1:0] r_src_col, r_src_row, r_bin_col, r_bin_row;
    logic [COORD_W-1:0] r_col_start, r_row_start, r_col_rem, r_row_rem;
    logic [SIZE_W-1:0]  r_col_edge, r_row_edge;

    logic [SIZE_W-1:0]  sw_e, sh_e, tw_e, th_e;
    t_dstep             cdiv_nx, rdiv_nx;
    logic               accept;

    // Current position, with a frame start marker taking effect first.
    logic [COORD_W-1:0] c_src_col, c_src_row, c_bin_col, c_bin_row;
    logic [COORD_W-1:0] c_col_start, c_row_start, c_col_rem, c_row_rem;
    logic [SIZE_W-1:0]  c_col_edge, c_row_edge;
    // Next position.
    logic [COORD_W-1:0] n_src_col, n_src_row, n_bin_col, n_bin_row;
    logic [COORD_W-1:0] n_col_start, n_row_start, n_col_rem, n_row_rem;
    logic [SIZE_W-1:0]  n_col_edge, n_row_edge;

    logic [SIZE_W-1:0]   nc, nr, col_rsum, row_rsum, cw, rh;
    logic [2*SIZE_W-1:0] prod;

    // Effective sizes from the written registers.
    assign sw_e = clamp_size(r_cfg_sw, SIZE_W'(MAX_WIDTH));
    assign sh_e = clamp_size(r_cfg_sh, SIZE_W'(MAX_HEIGHT));
    assign tw_e = clamp_size(r_cfg_tw, sw_e);
    assign th_e = clamp_size(r_cfg_th, sh_e);

    assign cdiv_nx = div_step(r_cdiv, r_tw);
    assign rdiv_nx = div_step(r_rdiv, r_th);

    assign o_ready = !r_pend && !r_busy && !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    // Classification of the pixel and the position after it.
    always_comb begin
        if (i_first_of_frame) begin
            c_src_col   = '0;
            c_src_row   = '0;
            c_bin_col   = '0;
            c_bin_row   = '0;
            c_col_start = '0;
            c_row_start = '0;
            c_col_edge  = r_qc;
            c_row_edge  = r_qr;
            c_col_rem   = r_rc;
            c_row_rem   = r_rr;
        end else begin
            c_src_col   = r_src_col;
            c_src_row   = r_src_row;
            c_bin_col   = r_bin_col;
            c_bin_row   = r_bin_row;
            c_col_start = r_col_start;
            c_row_start = r_row_start;
            c_col_edge  = r_col_edge;
            c_row_edge  = r_row_edge;
            c_col_rem   = r_col_rem;
            c_row_rem   = r_row_rem;
        end

        nc   = {1'b0, c_src_col} + SIZE_W'(1);
        nr   = {1'b0, c_src_row} + SIZE_W'(1);
        cw   = c_col_edge - {1'b0, c_col_start};
        rh   = c_row_edge - {1'b0, c_row_start};
        prod = (2*SIZE_W)'(cw) * (2*SIZE_W)'(rh);

        o_job.pixel   = i_pixel_in;
        o_job.seed    = (c_src_row == c_row_start) && (c_src_col == c_col_start);
        o_job.emit    = (nc == c_col_edge) && (nr == c_row_edge);
        o_job.count   = prod[COUNT_W-1:0];
        o_job.bin_col = c_bin_col;
        o_job.bin_row = c_bin_row;
        o_job.last    = (({1'b0, c_bin_col} + SIZE_W'(1)) == r_tw)
                     && (({1'b0, c_bin_row} + SIZE_W'(1)) == r_th);

        n_src_col   = nc[COORD_W-1:0];
        n_src_row   = c_src_row;
        n_bin_col   = c_bin_col;
        n_bin_row   = c_bin_row;
        n_col_start = c_col_start;
        n_row_start = c_row_start;
        n_col_edge  = c_col_edge;
        n_row_edge  = c_row_edge;
        n_col_rem   = c_col_rem;
        n_row_rem   = c_row_rem;
        col_rsum    = {1'b0, c_col_rem} + {1'b0, r_rc};
        row_rsum    = {1'b0, c_row_rem} + {1'b0, r_rr};

        // Step into the next column bin inside the row.
        if ((nc == c_col_edge) && (nc < r_sw)) begin
            n_bin_col   = c_bin_col + COORD_W'(1);
            n_col_start = c_col_edge[COORD_W-1:0];
            if (col_rsum >= r_tw) begin
                n_col_rem  = COORD_W'(col_rsum - r_tw);
                n_col_edge = c_col_edge + r_qc + SIZE_W'(1);
            end else begin
                n_col_rem  = col_rsum[COORD_W-1:0];
                n_col_edge = c_col_edge + r_qc;
            end
        end

        // End of a source row.
        if (nc >= r_sw) begin
            n_src_col   = '0;
            n_bin_col   = '0;
            n_col_start = '0;
            n_col_edge  = r_qc;
            n_col_rem   = r_rc;
            n_src_row   = nr[COORD_W-1:0];
            if (nr >= r_sh) begin
                n_src_row   = '0;
                n_bin_row   = '0;
                n_row_start = '0;
                n_row_edge  = r_qr;
                n_row_rem   = r_rr;
            end else if (nr == c_row_edge) begin
                n_bin_row   = c_bin_row + COORD_W'(1);
                n_row_start = nr[COORD_W-1:0];
                if (row_rsum >= r_th) begin
                    n_row_rem  = COORD_W'(row_rsum - r_th);
                    n_row_edge = c_row_edge + r_qr + SIZE_W'(1);
                end else begin
                    n_row_rem  = row_rsum[COORD_W-1:0];
                    n_row_edge = c_row_edge + r_qr;
                end
            end
        end
    end

    // Registers, setup sequencer and position update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sw    <= SIZE_W'(1);
            r_cfg_sh    <= SIZE_W'(1);
            r_cfg_tw    <= SIZE_W'(1);
            r_cfg_th    <= SIZE_W'(1);
            r_sw        <= SIZE_W'(1);
            r_sh        <= SIZE_W'(1);
            r_tw        <= SIZE_W'(1);
            r_th        <= SIZE_W'(1);
            r_qc        <= SIZE_W'(1);
            r_qr        <= SIZE_W'(1);
            r_rc        <= '0;
            r_rr        <= '0;
            r_pend      <= 1'b0;
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_bin_col   <= '0;
            r_bin_row   <= '0;
            r_col_start <= '0;
            r_row_start <= '0;
            r_col_edge  <= SIZE_W'(1);
            r_row_edge  <= SIZE_W'(1);
            r_col_rem   <= '0;
            r_row_rem   <= '0;
        end else if (i_cfg_we) begin
            // A valid write restarts the setup, which restarts the frame.
            case (i_cfg_index)
                REG_SOURCE_WIDTH: begin
                    r_cfg_sw <= i_cfg_data;
                    r_pend   <= 1'b1;
                    r_busy   <= 1'b0;
                end
                REG_SOURCE_HEIGHT: begin
                    r_cfg_sh <= i_cfg_data;
                    r_pend   <= 1'b1;
                    r_busy   <= 1'b0;
                end
                REG_TARGET_WIDTH: begin
                    r_cfg_tw <= i_cfg_data;
                    r_pend   <= 1'b1;
                    r_busy   <= 1'b0;
                end
                REG_TARGET_HEIGHT: begin
                    r_cfg_th <= i_cfg_data;
                    r_pend   <= 1'b1;
                    r_busy   <= 1'b0;
                end
                default: begin
                end
            endcase
        end else if (r_pend) begin
            r_pend      <= 1'b0;
            r_busy      <= 1'b1;
            r_step      <= '0;
            r_sw        <= sw_e;
            r_sh        <= sh_e;
            r_tw        <= tw_e;
            r_th        <= th_e;
            r_cdiv.num  <= sw_e;
            r_cdiv.rem  <= '0;
            r_rdiv.num  <= sh_e;
            r_rdiv.rem  <= '0;
        end else if (r_busy) begin
            r_cdiv <= cdiv_nx;
            r_rdiv <= rdiv_nx;
            r_step <= r_step + 4'd1;
            if (r_step == 4'(SIZE_W - 1)) begin
                r_busy      <= 1'b0;
                r_qc        <= cdiv_nx.num;
                r_rc        <= cdiv_nx.rem[COORD_W-1:0];
                r_qr        <= rdiv_nx.num;
                r_rr        <= rdiv_nx.rem[COORD_W-1:0];
                r_src_col   <= '0;
                r_src_row   <= '0;
                r_bin_col   <= '0;
                r_bin_row   <= '0;
                r_col_start <= '0;
                r_row_start <= '0;
                r_col_edge  <= cdiv_nx.num;
                r_row_edge  <= rdiv_nx.num;
                r_col_rem   <= cdiv_nx.rem[COORD_W-1:0];
                r_row_rem   <= rdiv_nx.rem[COORD_W-1:0];
            end
        end else if (accept) begin
            r_src_col   <= n_src_col;
            r_src_row   <= n_src_row;
            r_bin_col   <= n_bin_col;
            r_bin_row   <= n_bin_row;
            r_col_start <= n_col_start;
            r_row_start <= n_row_start;
            r_col_edge  <= n_col_edge;
            r_row_edge  <= n_row_edge;
            r_col_rem   <= n_col_rem;
            r_row_rem   <= n_row_rem;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bavg_fifo.sv @@
// ----------------------------------------------------------------------------
// bavg_fifo
// Short first-word fall-through queue between front end and accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module bavg_fifo import bavg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_data
);

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr, r_rptr;
    logic [QUEUE_PTR_W:0]   r_count;
    logic                   do_push, do_pop;

    assign o_full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QUEUE_PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QUEUE_PTR_W+1)'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bavg_back.sv @@
// ----------------------------------------------------------------------------
// bavg_back
// Column sum accumulator: read-modify-write of the per-column sum RAM,
// with forwarding between back-to-back transactions on the same column.
// ----------------------------------------------------------------------------
`default_nettype none

module bavg_back import bavg_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_req_valid,
    output t_avg_req  o_req,
    input  wire logic i_req_ready
);

    t_job             r_job;
    logic             r_jv;
    logic             r_fwd;
    logic [SUM_W-1:0] r_fwd_sum;
    logic [SUM_W-1:0] rd_data, base, sum;
    logic             a_go, b_go;

    bavg_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (b_go),
        .i_waddr (r_job.bin_col),
        .i_wdata (sum),
        .i_re    (a_go),
        .i_raddr (i_job.bin_col),
        .o_rdata (rd_data)
    );

    // Second stage: add the pixel to the stored or forwarded sum.
    assign base = r_fwd ? r_fwd_sum : rd_data;
    assign sum  = r_job.seed ? SUM_W'(r_job.pixel) : base + SUM_W'(r_job.pixel);
    assign b_go = r_jv && (!r_job.emit || i_req_ready);

    // First stage: take a transaction from the queue and start the read.
    assign a_go  = i_valid && (!r_jv || b_go);
    assign o_pop = a_go;

    assign o_req_valid   = r_jv && r_job.emit;
    assign o_req.sum     = sum;
    assign o_req.count   = r_job.count;
    assign o_req.bin_col = r_job.bin_col;
    assign o_req.bin_row = r_job.bin_row;
    assign o_req.last    = r_job.last;

    // Stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jv <= 1'b0;
        end else if (a_go) begin
            r_jv <= 1'b1;
        end else if (b_go) begin
            r_jv <= 1'b0;
        end
    end

    // Stage payload; a read issued while the same column is written
    // sees the old value, so the new sum is forwarded.
    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_job <= i_job;
            r_fwd <= b_go && (i_job.bin_col == r_job.bin_col);
        end
        if (b_go) begin
            r_fwd_sum <= sum;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bavg_div.sv @@
// ----------------------------------------------------------------------------
// bavg_div
// Pipelined restoring divider: one quotient bit per stage, bin sum over
// bin pixel count, stalling as a whole when the result is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bavg_div import bavg_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  t_avg_req           i_req,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [PIXEL_W-1:0] o_pixel,
    output logic [COORD_W-1:0] o_column,
    output logic [COORD_W-1:0] o_row,
    output logic               o_last
);

    typedef struct packed {
        logic [SUM_W-1:0]   rem;
        logic [COUNT_W-1:0] den;
        logic [PIXEL_W-1:0] quo;
        logic [COORD_W-1:0] bin_col;
        logic [COORD_W-1:0] bin_row;
        logic               last;
    } t_div_stage;

    t_div_stage r_stg [0:DIV_STAGES];
    t_div_stage n_stg [0:DIV_STAGES];
    logic       r_vld [0:DIV_STAGES];
    logic       en;

    assign en      = !r_vld[DIV_STAGES] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[DIV_STAGES];
    assign o_pixel = r_stg[DIV_STAGES].quo;
    assign o_column = r_stg[DIV_STAGES].bin_col;
    assign o_row   = r_stg[DIV_STAGES].bin_row;
    assign o_last  = r_stg[DIV_STAGES].last;

    // The average never exceeds the pixel range, so eight quotient bits
    // from the top down cover it.
    always_comb begin
        logic [SUM_W-1:0] d;
        n_stg[0].rem     = i_req.sum;
        n_stg[0].den     = i_req.count;
        n_stg[0].quo     = '0;
        n_stg[0].bin_col = i_req.bin_col;
        n_stg[0].bin_row = i_req.bin_row;
        n_stg[0].last    = i_req.last;
        for (int k = 0; k < DIV_STAGES; k++) begin
            d = SUM_W'(r_stg[k].den) << (PIXEL_W - 1 - k);
            n_stg[k+1] = r_stg[k];
            if (r_stg[k].rem >= d) begin
                n_stg[k+1].rem = r_stg[k].rem - d;
                n_stg[k+1].quo[PIXEL_W-1-k] = 1'b1;
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/box_average_image_downscaler.sv @@
// ----------------------------------------------------------------------------
// box_average_image_downscaler
// Area-average downscaler for 8-bit grayscale images streamed in raster order.
// ----------------------------------------------------------------------------
// Pixels are accepted at one per clock cycle while no setup runs and the
// queue is not full: the front end tracks the raster position and bin edges
// with adds and compares on each pixel, the accumulator does the column sum
// read-modify-write over two stages of its RAM with forwarding, and the
// averaging divider is a nine-stage pipeline that also takes one bin per
// cycle while its output is not stalled. After a write to one of the four
// size registers the front end works out the bin steps by restoring division
// and holds o_ready low meanwhile; the frame then starts from the top-left
// pixel. The column sum store needs no clearing, as every bin's sum is
// seeded by its first pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module box_average_image_downscaler import bavg_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [SIZE_W-1:0]      i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [PIXEL_W-1:0]     i_pixel_in,
    input  wire logic                   i_first_of_frame,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [PIXEL_W-1:0]          o_pixel_out,
    output logic [COORD_W-1:0]          o_out_column,
    output logic [COORD_W-1:0]          o_out_row,
    output logic                        o_last_of_frame
);

    t_job     push_job, head_job;
    logic     push, full, head_valid, pop;
    t_avg_req req;
    logic     req_valid, req_ready;

    // Front end: configuration and classification.
    bavg_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel_in       (i_pixel_in),
        .i_first_of_frame (i_first_of_frame),
        .o_push           (push),
        .o_job            (push_job),
        .i_full           (full)
    );

    // Queue between the two halves.
    bavg_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_data  (head_job)
    );

    // Back end: column sum accumulation.
    bavg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (head_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_ready (req_ready)
    );

    // Back end: averaging divider and output register.
    bavg_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (req_valid),
        .o_ready  (req_ready),
        .i_req    (req),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_pixel  (o_pixel_out),
        .o_column (o_out_column),
        .o_row    (o_out_row),
        .o_last   (o_last_of_frame)
    );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the box average image downscaler.
// ----------------------------------------------------------------------------
// A behavioural model of the binning and averaging, held in a small class,
// is stepped on every accepted pixel and queues the bins it expects. Each
// result transaction is matched field by field against the oldest queued
// bin. A short directed sequence covers reset sizes, clamped and zero sizes,
// ignored register indexes, frame wrap and resynchronisation. Random phases
// then follow, mostly whole frames with random content at random sizes.
// Both ports idle at random, with one stretch at full rate, one long output
// stall and several pauses until the output has drained.
// ----------------------------------------------------------------------------

module testbench;
    import bavg_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 12;
    localparam int IDLE_PERCENT   = 21;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int ITEM_TARGET    = 650;
    localparam int CAP_PIXELS     = 64;
    localparam int TIMEOUT_CYCLES = 250000;

    // An index past the last register; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 4'd9;

    typedef struct {
        logic [PIXEL_W-1:0] avg;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } t_bin;

    // Tracks the raster position and column sums, and queues finished bins.
    class box_average_checker;
        int unsigned     size_reg [4];
        longint unsigned col_sum [MAX_WIDTH];
        int unsigned     src_col, src_row, bin_col, bin_row;
        int unsigned     col_end, row_end, row_first;
        t_bin            bins_due [$];
        int unsigned     fault_count;

        function new();
            foreach (col_sum[i]) col_sum[i] = 0;
            foreach (size_reg[i]) size_reg[i] = 1;
            fault_count = 0;
            restart();
        endfunction

        static function int unsigned fit(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        // Boundary k of s source lines split into t bins.
        static function int unsigned bound_at(int unsigned k, int unsigned s,
                                              int unsigned t);
            longint unsigned prod;
            prod = k;
            prod = prod * s;
            return int'(prod / t);
        endfunction

        function void dims(output int unsigned sw, output int unsigned sh,
                           output int unsigned tw, output int unsigned th);
            sw = fit(size_reg[REG_SOURCE_WIDTH], MAX_WIDTH);
            sh = fit(size_reg[REG_SOURCE_HEIGHT], MAX_HEIGHT);
            tw = fit(size_reg[REG_TARGET_WIDTH], sw);
            th = fit(size_reg[REG_TARGET_HEIGHT], sh);
        endfunction

        function int unsigned frame_pixels();
            int unsigned sw, sh, tw, th;
            dims(sw, sh, tw, th);
            return sw * sh;
        endfunction

        function void restart();
            int unsigned sw, sh, tw, th;
            dims(sw, sh, tw, th);
            src_col   = 0;
            src_row   = 0;
            bin_col   = 0;
            bin_row   = 0;
            row_first = 0;
            col_end   = bound_at(1, sw, tw);
            row_end   = bound_at(1, sh, th);
        endfunction

        // Any write to a real register restarts the frame, changed or not.
        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [SIZE_W-1:0] val);
            case (idx)
                REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT,
                REG_TARGET_WIDTH, REG_TARGET_HEIGHT: begin
                    size_reg[idx[1:0]] = val;
                    restart();
                end
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return bins_due.size();
        endfunction

        // One accepted pixel transaction.
        function void take_pixel(logic [PIXEL_W-1:0] pix, logic sof);
            int unsigned     sw, sh, tw, th, col_first, idx;
            longint unsigned area;
            t_bin            fin;
            dims(sw, sh, tw, th);
            if (sof) restart();

            // Accumulate; the first pixel of a bin in its band seeds the sum.
            idx       = bin_col % MAX_WIDTH;
            col_first = bound_at(bin_col, sw, tw);
            if (src_row == row_first && src_col == col_first) col_sum[idx] = pix;
            else col_sum[idx] += pix;

            // The bottom-right pixel of a bin finishes it.
            if (src_col + 1 == col_end && src_row + 1 == row_end) begin
                area     = col_end - col_first;
                area     = area * (row_end - row_first);
                fin.avg  = (area != 0) ? PIXEL_W'(col_sum[idx] / area) : '0;
                fin.col  = COORD_W'(bin_col);
                fin.row  = COORD_W'(bin_row);
                fin.last = (bin_col + 1 == tw && bin_row + 1 == th);
                bins_due.push_back(fin);
            end

            // Step along the row, then down the frame, wrapping at the end.
            src_col++;
            if (src_col == col_end && src_col < sw) begin
                bin_col++;
                col_end = bound_at(bin_col + 1, sw, tw);
            end
            if (src_col >= sw) begin
                src_col = 0;
                bin_col = 0;
                col_end = bound_at(1, sw, tw);
                src_row++;
                if (src_row >= sh) begin
                    src_row   = 0;
                    bin_row   = 0;
                    row_first = 0;
                    row_end   = bound_at(1, sh, th);
                end else if (src_row == row_end) begin
                    bin_row++;
                    row_first = src_row;
                    row_end   = bound_at(bin_row + 1, sh, th);
                end
            end
        endfunction

        // One accepted result transaction.
        function void match_bin(logic [PIXEL_W-1:0] avg, logic [COORD_W-1:0] col,
                                logic [COORD_W-1:0] row, logic last);
            t_bin want;
            if (bins_due.size() == 0) begin
                $display("%0t: unexpected result avg=%0d col=%0d row=%0d last=%0b",
                         $time, avg, col, row, last);
                fault_count++;
                return;
            end
            want = bins_due.pop_front();
            if (avg !== want.avg) begin
                $display("%0t: pixel_out expected %0d, got %0d", $time, want.avg, avg);
                fault_count++;
            end
            if (col !== want.col) begin
                $display("%0t: out_column expected %0d, got %0d", $time, want.col, col);
                fault_count++;
            end
            if (row !== want.row) begin
                $display("%0t: out_row expected %0d, got %0d", $time, want.row, row);
                fault_count++;
            end
            if (last !== want.last) begin
                $display("%0t: last_of_frame expected %0b, got %0b",
                         $time, want.last, last);
                fault_count++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [SIZE_W-1:0]      i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    logic [PIXEL_W-1:0]     i_pixel_in;
    logic                   i_first_of_frame;
    logic                   o_valid;
    logic                   i_ready;
    logic [PIXEL_W-1:0]     o_pixel_out;
    logic [COORD_W-1:0]     o_out_column;
    logic [COORD_W-1:0]     o_out_row;
    logic                   o_last_of_frame;

    box_average_checker boxes;
    bit                 steady   = 1'b0;
    bit                 hold_req = 1'b0;
    int unsigned        pixels_sent = 0;

    box_average_image_downscaler dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel_in       (i_pixel_in),
        .i_first_of_frame (i_first_of_frame),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pixel_out      (o_pixel_out),
        .o_out_column     (o_out_column),
        .o_out_row        (o_out_row),
        .o_last_of_frame  (o_last_of_frame)
    );

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("testbench: errors");
        $finish;
    end

    // Result side: check every accepted transaction and stall at random.
    initial begin
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                boxes.match_bin(o_pixel_out, o_out_column, o_out_row, o_last_of_frame);
            if (hold_req) begin
                // Long hold-off so the pipeline backs up into the input.
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    function automatic logic [PIXEL_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] random_size(int unsigned usual);
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return SIZE_W'(MAX_WIDTH);
            2:       return '1;
            3:       return SIZE_W'($urandom_range(0, 8191));
            default: return SIZE_W'($urandom_range(1, usual));
        endcase
    endfunction

    // Offer one pixel, after an optional random gap, and wait for acceptance.
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic sof);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_pixel_in       <= pix;
        i_first_of_frame <= sof;
        do @(posedge i_clk); while (!o_ready);
        boxes.take_pixel(pix, sof);
        pixels_sent++;
    endtask

    // Pixels of one frame; with noise the frame markers fall at random.
    task automatic send_frame(input int unsigned count, input bit noise);
        logic sof;
        for (int unsigned k = 0; k < count; k++) begin
            if (noise) sof = ($urandom_range(0, 9) == 0);
            else sof = (k == 0);
            send_pixel(random_pixel(), sof);
        end
    endtask

    // Stop offering until every expected bin is out, then let the pipe settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (boxes.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [SIZE_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        boxes.set_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(input logic [SIZE_W-1:0] sw, input logic [SIZE_W-1:0] sh,
                             input logic [SIZE_W-1:0] tw, input logic [SIZE_W-1:0] th);
        wait_idle();
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_TARGET_WIDTH, tw);
        write_reg(REG_TARGET_HEIGHT, th);
    endtask

    // Stimulus.
    initial begin
        int unsigned n;
        int unsigned frames;
        bit          noise;

        boxes            = new();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = REG_SOURCE_WIDTH;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_pixel_in       = '0;
        i_first_of_frame = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset sizes are 1x1: every pixel is a bin and the frame wraps alone.
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b0);

        // 4x2 into 2x1: two 2x2 boxes with extreme values.
        set_sizes(13'd4, 13'd2, 13'd2, 13'd1);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFE, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b0);

        // Zero sizes behave as one.
        set_sizes(13'd0, 13'd0, 13'd0, 13'd0);
        send_pixel(8'hAA, 1'b1);

        // Upscale request is clamped to a plain copy.
        set_sizes(13'd3, 13'd1, 13'h1FFF, 13'd5);
        send_frame(3, 1'b0);

        // Oversized width saturates; an unused index leaves the frame running,
        // while rewriting an unchanged register sends it back to the start.
        set_sizes(13'h1FFF, 13'd1, 13'd4096, 13'd1);
        send_pixel(8'h55, 1'b1);
        send_pixel(8'h80, 1'b0);
        wait_idle();
        write_reg(REG_UNUSED, 13'd5);
        send_pixel(8'h7F, 1'b0);
        wait_idle();
        write_reg(REG_SOURCE_WIDTH, 13'h1FFF);
        send_pixel(8'h01, 1'b0);

        // A frame marker part way through resynchronises the counters.
        set_sizes(13'd2, 13'd2, 13'd1, 13'd1);
        send_frame(3, 1'b0);
        send_frame(4, 1'b0);

        // Full rate on both sides over two copied frames.
        set_sizes(13'd12, 13'd8, 13'd12, 13'd8);
        steady = 1'b1;
        send_frame(96, 1'b0);
        send_frame(96, 1'b0);
        steady = 1'b0;

        // Output held off while the input keeps offering.
        set_sizes(13'd10, 13'd10, 13'd10, 13'd10);
        hold_req = 1'b1;
        send_frame(100, 1'b0);

        // Random phases: mostly whole frames at random sizes.
        while (pixels_sent < ITEM_TARGET) begin
            wait_idle();
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(0, 3)), random_size(12));
            else begin
                write_reg(REG_SOURCE_WIDTH, random_size(10));
                write_reg(REG_SOURCE_HEIGHT, random_size(10));
                write_reg(REG_TARGET_WIDTH, random_size(12));
                write_reg(REG_TARGET_HEIGHT, random_size(12));
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(4, 15)), SIZE_W'($urandom));
            frames = $urandom_range(1, 3);
            noise  = ($urandom_range(0, 9) == 0);
            repeat (frames) begin
                n = boxes.frame_pixels();
                if (n > CAP_PIXELS) n = $urandom_range(8, CAP_PIXELS);
                // Now and then a frame is cut short.
                if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
                send_frame(n, noise);
                if ($urandom_range(0, 7) == 0) wait_idle();
            end
        end

        wait_idle();
        if (boxes.fault_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ box_average_image_downscaler.f @@
hw/rtl/bavg_pkg.sv
hw/rtl/bavg_ram.sv
hw/rtl/bavg_front.sv
hw/rtl/bavg_fifo.sv
hw/rtl/bavg_back.sv
hw/rtl/bavg_div.sv
hw/rtl/box_average_image_downscaler.sv
bench/testbench.sv
